/* sv/pet_pkg.sv */
// Package: shared types and constants of the priced entry table.
`default_nettype none
package pet_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND   = 3'd0,
    MODE_PRICE    = 3'd1,
    MODE_REMOVE   = 3'd2,
    MODE_LOOKUP   = 3'd3,
    MODE_EXPIRE   = 3'd4,
    MODE_LIST     = 3'd5,
    MODE_MATCHED  = 3'd6,
    MODE_RESERVED = 3'd7
  } mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] entry_key;
    logic [31:0] price;
    logic [31:0] created_at;
    logic [31:0] lifetime;
    logic [31:0] quantity;
    logic        matched_in;
    logic [31:0] now;
    logic [5:0]  list_count;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic        full_res;
    logic [63:0] out_key;
    logic [31:0] out_price;
    logic [31:0] out_quantity;
    logic        out_matched;
    logic [5:0]  entry_count;
    logic [5:0]  matched_count;
    logic [35:0] removed_quantity;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [31:0] price;
    logic [31:0] created;
    logic [31:0] lifetime;
    logic [31:0] quantity;
    logic        matched;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam logic [35:0] QSUM_MAX = 36'hF_FFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_PUT,
    ST_PACK,
    ST_RESULT,
    ST_LIST_RD,
    ST_LIST_WAIT
  } state_e;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_SCAN,
    PH_SHIFT,
    PH_PACK,
    PH_LIST
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   rd;
    phase_e phase;
    logic   shift_init;
    logic   put;
    logic   mark_full;
    logic   pack_end;
    logic   emit;
    logic   emit_list;
  } cmd_t;

  typedef struct packed {
    logic [2:0] in_mode;
    logic [2:0] mode;
    logic       rd_more;
    logic       rdv;
    logic       out_free;
    logic       hit;
    logic       full;
    logic       list_empty;
    logic       list_last;
  } sts_t;

endpackage
`default_nettype wire

/* sv/priced_entry_table_with_expiry.sv */
// Top level: price ordered entry table with key lookup, removal and expiry.
// Lookup and matched count scan the held entries, remove and expiry compact them, an
// insert scans and then shifts the tail, and a list reads out each listed entry in turn.
// One item is in flight at a time; the next beat is taken once the last result has been
// placed in the output register. The single memory port pair sets the pace. Reset clears
// the entry count and all control state, not the memory.
`default_nettype none
module priced_entry_table_with_expiry #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire pet_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pet_pkg::out_t      out_data_o
);
  import pet_pkg::*;

  // The controller only walks the phases; all pointers and data live in the datapath.
  cmd_t cmd;
  sts_t sts;

  pet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Entries live in one memory word each. Inserts shift the tail back one slot,
  // removal and expiry compact the table in a single read/write pass.
  pet_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* sv/pet_ram.sv */
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module pet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* sv/pet_ctrl.sv */
// Controller: sequences the scan, shift, compaction, list and result phases.
`default_nettype none
module pet_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire pet_pkg::sts_t sts_i,
  output pet_pkg::cmd_t      cmd_o
);
  import pet_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.phase = PH_NONE;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (sts_i.in_mode)
            MODE_APPEND, MODE_PRICE, MODE_LOOKUP, MODE_MATCHED: state_d = ST_SCAN;
            MODE_REMOVE, MODE_EXPIRE: state_d = ST_PACK;
            MODE_LIST: state_d = ST_LIST_RD;
            default: state_d = ST_RESULT;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.phase = PH_SCAN;
        cmd_o.rd    = sts_i.rd_more;
        if (!sts_i.rd_more && !sts_i.rdv) begin
          if (sts_i.mode == MODE_APPEND || sts_i.mode == MODE_PRICE) begin
            state_d = ST_DECIDE;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_DECIDE: begin
        priority if (sts_i.hit) begin
          state_d = ST_RESULT;
        end else if (sts_i.full) begin
          cmd_o.mark_full = 1'b1;
          state_d = ST_RESULT;
        end else begin
          cmd_o.shift_init = 1'b1;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd_o.phase = PH_SHIFT;
        cmd_o.rd    = sts_i.rd_more;
        if (!sts_i.rd_more && !sts_i.rdv) begin
          state_d = ST_PUT;
        end
      end
      ST_PUT: begin
        cmd_o.put = 1'b1;
        state_d = ST_RESULT;
      end
      ST_PACK: begin
        cmd_o.phase = PH_PACK;
        cmd_o.rd    = sts_i.rd_more;
        if (!sts_i.rd_more && !sts_i.rdv) begin
          cmd_o.pack_end = 1'b1;
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_LIST_RD: begin
        cmd_o.phase = PH_LIST;
        if (sts_i.list_empty) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = ST_LIST_WAIT;
        end
      end
      ST_LIST_WAIT: begin
        cmd_o.phase = PH_LIST;
        if (sts_i.out_free) begin
          cmd_o.emit_list = 1'b1;
          state_d = sts_i.list_last ? ST_IDLE : ST_LIST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* sv/pet_dp.sv */
// Datapath: entry memory, scan pointers, accumulators and the result register.
`default_nettype none
module pet_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pet_pkg::in_t   in_data_i,
  input  wire pet_pkg::cmd_t  cmd_i,
  output pet_pkg::sts_t       sts_o,
  input  wire logic           out_stall_i,
  output logic                out_valid_o,
  output pet_pkg::out_t       out_data_o
);
  import pet_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW = (CW > 6) ? CW : 6;

  in_t            item_q;
  entry_t         cap_q;
  out_t           out_q, res_single, res_list;
  logic [CW-1:0]  occ_q, rp_q, wp_q, pos_q, mcnt_q, n_list, lim, rp_dec;
  logic           pos_found_q, hit_q, full_q, put_q, rdv_q, out_valid_q;
  logic [IW-1:0]  rdi_q;
  logic [35:0]    sum_q, sum_next;
  logic [36:0]    sum_add;
  logic [NW-1:0]  lc_w, occ_w;

  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  entry_t              rd_e, new_e;
  logic                key_eq, expired, drop;

  pet_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rd_e    = entry_t'(ram_rdata);
    new_e   = '{key: item_q.entry_key, price: item_q.price, created: item_q.created_at,
                lifetime: item_q.lifetime, quantity: item_q.quantity,
                matched: item_q.matched_in};
    lc_w    = NW'(item_q.list_count);
    occ_w   = NW'(occ_q);
    n_list  = (lc_w != '0 && lc_w < occ_w) ? CW'(lc_w) : occ_q;
    lim     = (cmd_i.phase == PH_LIST) ? n_list : occ_q;
    rp_dec  = rp_q - CW'(1);
    key_eq  = rd_e.key == item_q.entry_key;
    expired = ({1'b0, rd_e.created} + {1'b0, rd_e.lifetime}) < {1'b0, item_q.now};
    drop    = (item_q.mode == MODE_REMOVE) ? (key_eq && !hit_q) : expired;
    sum_add = {1'b0, sum_q} + {5'b0, rd_e.quantity};
    sum_next = sum_add[36] ? QSUM_MAX : sum_add[35:0];

    ram_re    = cmd_i.rd;
    ram_raddr = (cmd_i.phase == PH_SHIFT) ? rp_dec[IW-1:0] : rp_q[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = rdi_q + IW'(1);
    ram_wdata = ram_rdata;
    if (cmd_i.put) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q[IW-1:0];
      ram_wdata = new_e;
    end else if (rdv_q && cmd_i.phase == PH_SHIFT) begin
      ram_we = 1'b1;
    end else if (rdv_q && cmd_i.phase == PH_PACK && !drop) begin
      ram_we    = 1'b1;
      ram_waddr = wp_q[IW-1:0];
    end

    sts_o.in_mode    = in_data_i.mode;
    sts_o.mode       = item_q.mode;
    sts_o.rd_more    = (cmd_i.phase == PH_SHIFT) ? (rp_q > pos_q) : (rp_q < lim);
    sts_o.rdv        = rdv_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
    sts_o.hit        = hit_q;
    sts_o.full       = occ_q == CW'(TABLE_DEPTH);
    sts_o.list_empty = n_list == '0;
    sts_o.list_last  = rp_q == n_list;

    res_single = '0;
    res_single.entry_count = 6'(occ_q);
    res_single.last = 1'b1;
    unique case (item_q.mode)
      MODE_APPEND, MODE_PRICE: begin
        res_single.ok       = put_q;
        res_single.full_res = full_q;
      end
      MODE_REMOVE: res_single.ok = hit_q;
      MODE_LOOKUP: begin
        res_single.ok = hit_q;
        if (hit_q) begin
          res_single.out_key      = cap_q.key;
          res_single.out_price    = cap_q.price;
          res_single.out_quantity = cap_q.quantity;
          res_single.out_matched  = cap_q.matched;
        end
      end
      MODE_EXPIRE:  res_single.removed_quantity = sum_q;
      MODE_MATCHED: res_single.matched_count = 6'(mcnt_q);
      default: ;
    endcase

    res_list = '0;
    res_list.ok           = 1'b1;
    res_list.out_key      = rd_e.key;
    res_list.out_price    = rd_e.price;
    res_list.out_quantity = rd_e.quantity;
    res_list.out_matched  = rd_e.matched;
    res_list.entry_count  = 6'(occ_q);
    res_list.last         = rp_q == n_list;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      pos_q       <= '0;
      pos_found_q <= 1'b0;
      hit_q       <= 1'b0;
      full_q      <= 1'b0;
      put_q       <= 1'b0;
      mcnt_q      <= '0;
      rdv_q       <= 1'b0;
      rdi_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rdv_q       <= cmd_i.rd;
      out_valid_q <= cmd_i.emit || cmd_i.emit_list || (out_valid_q && out_stall_i);
      if (cmd_i.load) begin
        rp_q        <= '0;
        wp_q        <= '0;
        pos_q       <= '0;
        pos_found_q <= 1'b0;
        hit_q       <= 1'b0;
        full_q      <= 1'b0;
        put_q       <= 1'b0;
        mcnt_q      <= '0;
      end
      if (cmd_i.rd) begin
        rp_q  <= (cmd_i.phase == PH_SHIFT) ? rp_dec : rp_q + CW'(1);
        rdi_q <= ram_raddr;
      end
      if (rdv_q && cmd_i.phase == PH_SCAN) begin
        if (key_eq && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!pos_found_q && rd_e.price <= item_q.price) begin
          pos_found_q <= 1'b1;
          pos_q       <= CW'(rdi_q);
        end
        if (rd_e.matched) begin
          mcnt_q <= mcnt_q + CW'(1);
        end
      end
      if (rdv_q && cmd_i.phase == PH_PACK) begin
        if (drop) begin
          if (item_q.mode == MODE_REMOVE) begin
            hit_q <= 1'b1;
          end
        end else begin
          wp_q <= wp_q + CW'(1);
        end
      end
      if (cmd_i.shift_init) begin
        rp_q  <= occ_q;
        pos_q <= (item_q.mode == MODE_APPEND || !pos_found_q) ? occ_q : pos_q;
      end
      if (cmd_i.put) begin
        occ_q <= occ_q + CW'(1);
        put_q <= 1'b1;
      end
      if (cmd_i.mark_full) begin
        full_q <= 1'b1;
      end
      if (cmd_i.pack_end) begin
        occ_q <= wp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
      sum_q  <= '0;
    end
    if (rdv_q && cmd_i.phase == PH_SCAN && key_eq && !hit_q) begin
      cap_q <= rd_e;
    end
    if (rdv_q && cmd_i.phase == PH_PACK && drop && item_q.mode == MODE_EXPIRE) begin
      sum_q <= sum_next;
    end
    if (cmd_i.emit) begin
      out_q <= res_single;
    end else if (cmd_i.emit_list) begin
      out_q <= res_list;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
